### rtl/assert_macros.svh
// assertion helpers used by the key_value_table module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent assertion on the house clock and reset
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/kvt_pkg.sv
`default_nettype none
package kvt_pkg;

  // default sizing
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned POSITION_W  = 4;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ENTRY_CNT_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET      = 3'd0,
    OP_PUT      = 3'd1,
    OP_ADD      = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_READ_AT  = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_DUP_KEY   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_POSITION  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // control handed to every cell of the ring
  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/kvt_cell.sv
`default_nettype none
module kvt_cell
  import kvt_pkg::*;
#(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [KEY_BITS-1:0]   nbr_key_i,
  input  wire logic [VALUE_BITS-1:0] nbr_value_i,
  output logic      [KEY_BITS-1:0]   key_o,
  output logic      [VALUE_BITS-1:0] value_o
);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // take the neighbor's pair on every shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q   <= nbr_key_i;
      value_q <= nbr_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule
`default_nettype wire

### rtl/key_value_table.sv
// flow: an accepted request scans one full turn of the cell ring, then its result is
// loaded into the output register in the flush state; a request is taken only when idle
// the next request is taken while the previous result still waits at the output
// reset: asynchronous active low; clears the entry count, the sequencer and output valid
// pair storage has no reset; only entries below the count are ever read
`default_nettype none
`include "assert_macros.svh"
module key_value_table
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [OPCODE_W-1:0]    opcode_i,
  input  wire logic [FIELD_W-1:0]     key_i,
  input  wire logic [FIELD_W-1:0]     value_i,
  input  wire logic [POSITION_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [STATUS_W-1:0]    status_o,
  output logic                        found_o,
  output logic      [FIELD_W-1:0]     out_key_o,
  output logic      [FIELD_W-1:0]     out_value_o,
  output logic      [ENTRY_CNT_W-1:0] entry_count_o
);

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // sequencer and request registers
  state_e                state_q, state_d;
  logic [SW-1:0]         step_q, step_d;
  logic [CW-1:0]         count_q, count_d;
  opcode_e               op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [POSITION_W-1:0] pos_q;
  logic                  full_q;
  logic                  pos_ok_q;
  logic                  found_q, found_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic                   ofound_q, ofound_d;
  logic [FIELD_W-1:0]     okey_q, okey_d;
  logic [FIELD_W-1:0]     oval_q, oval_d;
  logic [CW-1:0]          ocount_q;
  logic                   out_load;

  // ring of cells
  cell_ctrl_t            cell_ctrl;
  logic [KEY_BITS-1:0]   cell_key[CAPACITY];
  logic [VALUE_BITS-1:0] cell_val[CAPACITY];
  logic [KEY_BITS-1:0]   tail_key;
  logic [VALUE_BITS-1:0] tail_val;

  // scan decode at the head of the ring
  logic accept;
  logic scan_last;
  logic in_range;
  logic at_count;
  logic is_insert;
  logic is_lookup;
  logic match_now;
  logic hit;
  logic [2*CW-1:0] ocount_ext;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign scan_last = (state_q == ST_SCAN) && (step_q == SW'(CAPACITY - 1));
  assign in_range  = CW'(step_q) < count_q;
  assign at_count  = CW'(step_q) == count_q;
  assign is_insert = (op_q == OP_GET) || (op_q == OP_PUT) || (op_q == OP_ADD);
  assign is_lookup = is_insert || (op_q == OP_CONTAINS) || (op_q == OP_REMOVE);
  assign match_now = (state_q == ST_SCAN) && is_lookup && in_range && (cell_key[0] == key_q);
  assign hit       = found_q || match_now;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      kvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl),
        .nbr_key_i   (tail_key),
        .nbr_value_i (tail_val),
        .key_o       (cell_key[i]),
        .value_o     (cell_val[i])
      );
    end else begin : g_body
      kvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl),
        .nbr_key_i   (cell_key[i+1]),
        .nbr_value_i (cell_val[i+1]),
        .key_o       (cell_key[i]),
        .value_o     (cell_val[i])
      );
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_e'(opcode_i);
      key_q    <= KEY_BITS'(key_i);
      val_q    <= VALUE_BITS'(value_i);
      pos_q    <= position_i;
      full_q   <= count_q == CW'(CAPACITY);
      pos_ok_q <= 32'(position_i) < 32'(count_q);
    end
    found_q   <= found_d;
    res_key_q <= res_key_d;
    res_val_q <= res_val_d;
    if (out_load) begin
      status_q <= status_d;
      ofound_q <= ofound_d;
      okey_q   <= okey_d;
      oval_q   <= oval_d;
      ocount_q <= count_q;
    end
  end

  // next state, ring feed and entry count
  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    count_d         = count_q;
    cell_ctrl.shift = 1'b0;
    tail_key        = cell_key[0];
    tail_val        = cell_val[0];
    found_d         = found_q;
    res_key_d       = res_key_q;
    res_val_d       = res_val_q;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          step_d  = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        step_d          = step_q + SW'(1);
        if (match_now) begin
          found_d   = 1'b1;
          res_val_d = (op_q == OP_PUT) ? val_q : cell_val[0];
        end
        if ((op_q == OP_READ_AT) && (32'(step_q) == 32'(pos_q))) begin
          res_key_d = cell_key[0];
          res_val_d = cell_val[0];
        end
        // put replaces the value as the entry passes the head
        if ((op_q == OP_PUT) && match_now) begin
          tail_val = val_q;
        end
        // remove pulls every later entry down by one
        if ((op_q == OP_REMOVE) && hit) begin
          tail_key = cell_key[1];
          tail_val = cell_val[1];
        end
        // append lands in the first free slot once all entries are checked
        if (is_insert && !found_q && at_count) begin
          tail_key = key_q;
          tail_val = (op_q == OP_GET) ? '0 : val_q;
        end
        if (scan_last) begin
          state_d = ST_FLUSH;
          case (op_q)
            OP_GET, OP_PUT, OP_ADD: begin
              if (!hit && !full_q) begin
                count_d = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                count_d = count_q - CW'(1);
              end
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result fields
  always_comb begin
    status_d = STAT_OK;
    ofound_d = 1'b0;
    okey_d   = 32'(key_q);
    oval_d   = '0;
    case (op_q)
      OP_GET, OP_PUT, OP_ADD: begin
        ofound_d = found_q;
        if (found_q) begin
          oval_d = 32'(res_val_q);
          if (op_q == OP_ADD) begin
            status_d = STAT_DUP_KEY;
          end
        end else if (full_q) begin
          status_d = STAT_FULL;
        end else if (op_q != OP_GET) begin
          oval_d = 32'(val_q);
        end
      end
      OP_CONTAINS, OP_REMOVE: begin
        ofound_d = found_q;
        if (found_q) begin
          oval_d = 32'(res_val_q);
        end else begin
          status_d = STAT_NOT_FOUND;
        end
      end
      OP_READ_AT: begin
        if (pos_ok_q) begin
          okey_d = 32'(res_key_q);
          oval_d = 32'(res_val_q);
        end else begin
          status_d = STAT_POSITION;
          okey_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign ocount_ext    = (2*CW)'(ocount_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = ofound_q;
  assign out_key_o     = okey_q;
  assign out_value_o   = oval_q;
  assign entry_count_o = ENTRY_CNT_W'(ocount_ext);

  `ASSERT_STD(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `ASSERT_STD(a_count_at_end, !$stable(count_q) |-> $past(scan_last), "count moved mid scan")
  `ASSERT_STD(a_unique_key, match_now |-> !found_q, "key matched twice in one scan")
  `ASSERT_STD(a_result_after_scan, $rose(out_valid_q) |-> $past(state_q == ST_FLUSH),
              "result raised outside flush")

endmodule
`default_nettype wire
